FILE: src/dmarb_pkg.sv
// Shared types, codes and sizes for the DMA request ring with frame budget.
// No dependencies; imported by the top level.
package dmarb_pkg;

    // Ring geometry
    localparam int SLOT_COUNT = 128;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);

    // Accumulator widths
    localparam int PEND_W = 23;
    localparam int PASS_W = 21;
    localparam logic [PEND_W-1:0] PEND_MAX = {PEND_W{1'b1}};
    localparam logic [PASS_W-1:0] PASS_MAX = {PASS_W{1'b1}};

    // Configuration registers
    localparam int BUDGET_W = 20;
    localparam int CUTOFF_W = 8;
    localparam int CFG_W    = BUDGET_W;
    localparam logic [BUDGET_W-1:0] BUDGET_RESET = BUDGET_W'(40 * 1024);
    localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = CUTOFF_W'(224);
    localparam logic CFG_BUDGET = 1'b0;
    localparam logic CFG_CUTOFF = 1'b1;

    // Operation codes
    localparam logic [2:0] OP_CLEAR = 3'd0;
    localparam logic [2:0] OP_COPY  = 3'd1;
    localparam logic [2:0] OP_FILL  = 3'd2;
    localparam logic [2:0] OP_BEGIN = 3'd3;
    localparam logic [2:0] OP_STEP  = 3'd4;
    localparam logic [2:0] OP_SPACE = 3'd5;

    // Result kinds
    localparam logic [2:0] RK_CLEARED  = 3'd0;
    localparam logic [2:0] RK_ACCEPTED = 3'd1;
    localparam logic [2:0] RK_REFUSED  = 3'd2;
    localparam logic [2:0] RK_XFER     = 3'd3;
    localparam logic [2:0] RK_ENDED    = 3'd4;
    localparam logic [2:0] RK_STARTED  = 3'd5;
    localparam logic [2:0] RK_SPACE    = 3'd6;

    // Transfer kinds: bit 0 marks a fill, bit 1 marks 16-bit units
    localparam logic [1:0] XK_COPY32 = 2'd0;
    localparam logic [1:0] XK_FILL32 = 2'd1;
    localparam logic [1:0] XK_COPY16 = 2'd2;
    localparam logic [1:0] XK_FILL16 = 2'd3;

    // End reasons
    localparam logic [1:0] ER_DRAINED = 2'd0;
    localparam logic [1:0] ER_BUDGET  = 2'd1;
    localparam logic [1:0] ER_CUTOFF  = 2'd2;

    // One ring entry as held in the slot memory
    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dest;
        logic [15:0] size;
        logic [1:0]  kind;
        logic [31:0] fill;
    } slot_entry_t;

    localparam int ENTRY_W = $bits(slot_entry_t);

    // Captured input item
    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] src_addr;
        logic [31:0] dest_addr;
        logic [15:0] size;
        logic        wide_mode;
        logic [31:0] fill_value;
        logic [7:0]  scanline;
        logic [6:0]  slot_index;
        logic        check_all;
    } in_item_t;

    // Result item
    typedef struct packed {
        logic [2:0]        result_kind;
        logic [6:0]        slot;
        logic [1:0]        xfer_kind;
        logic [31:0]       xfer_src;
        logic [31:0]       xfer_dest;
        logic [15:0]       xfer_size;
        logic [31:0]       xfer_value;
        logic [1:0]        end_reason;
        logic [PEND_W-1:0] bytes_done;
        logic [PEND_W-1:0] bytes_pending;
        logic [PEND_W-1:0] peak_bytes;
        logic              space_free;
    } result_t;

endpackage

FILE: src/dmarb_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module dmarb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: src/dma_request_ring_with_frame_budget_unit.sv
// Top level of the DMA request ring with per-pass byte budget and scanline cutoff.
// Depends on dmarb_pkg and dmarb_ram (slot memory).

// Every item passes an accept step, in which the slot memory
// reads the entry under the service cursor, and an execute step that
// searches the occupancy flags, updates the counters and writes the slot
// memory. The execute step holds while the result register is still full,
// so a new item is taken while an earlier result waits. Slot occupancy lives
// in one flip-flop per slot, which reset and the clear operation zero all
// together, so there is no clearing pass after reset. Configuration
// writes land at once and must come while the block is idle.
module dma_request_ring_with_frame_budget_unit
    import dmarb_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_operation,
    input  logic [31:0]         s_src_addr,
    input  logic [31:0]         s_dest_addr,
    input  logic [15:0]         s_size,
    input  logic                s_wide_mode,
    input  logic [31:0]         s_fill_value,
    input  logic [7:0]          s_scanline,
    input  logic [6:0]          s_slot_index,
    input  logic                s_check_all,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_result_kind,
    output logic [6:0]          m_slot,
    output logic [1:0]          m_xfer_kind,
    output logic [31:0]         m_xfer_src,
    output logic [31:0]         m_xfer_dest,
    output logic [15:0]         m_xfer_size,
    output logic [31:0]         m_xfer_value,
    output logic [1:0]          m_end_reason,
    output logic [PEND_W-1:0]   m_bytes_done,
    output logic [PEND_W-1:0]   m_bytes_pending,
    output logic [PEND_W-1:0]   m_peak_bytes,
    output logic                m_space_free,

    input  logic                cfg_wr_en,
    input  logic                cfg_index,
    input  logic [CFG_W-1:0]    cfg_wdata
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                  state_reg, state_next;
    in_item_t              in_reg;
    result_t               res_reg, res_next;
    logic                  m_valid_reg, m_valid_next;
    logic [SLOT_COUNT-1:0] occ_reg, occ_next;
    logic [SLOT_W-1:0]     cursor_reg, cursor_next;
    logic [PEND_W-1:0]     pending_reg, pending_next;
    logic [PEND_W-1:0]     start_reg, start_next;
    logic [PEND_W-1:0]     peak_reg, peak_next;
    logic [PASS_W-1:0]     pass_reg, pass_next;
    logic [BUDGET_W-1:0]   budget_reg;
    logic [CUTOFF_W-1:0]   cutoff_reg;

    logic                  accept;
    logic                  commit;
    logic                  has_result;

    // Slot memory signals
    logic                  ram_we;
    slot_entry_t           ram_wdata;
    slot_entry_t           ram_rdata;
    logic [ENTRY_W-1:0]    ram_rbits;

    // Free-slot search
    logic [SLOT_COUNT-1:0] free_vec, above_mask, pick_vec, first_vec;
    logic                  found;
    logic [SLOT_W-1:0]     found_idx;

    // Arithmetic helpers
    logic [PEND_W:0]       pend_sum;
    logic [PASS_W:0]       pass_sum;
    logic [PASS_W-1:0]     pass_sat;
    logic [PEND_W-1:0]     done_bytes;
    logic [PEND_W-1:0]     cur_size;
    logic                  cur_occ;
    logic                  over_budget;
    logic                  too_late;
    logic [SLOT_W-1:0]     cursor_inc;
    logic [SLOT_W-1:0]     check_idx;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign commit  = (state_reg == ST_EXEC) && (!m_valid_reg || m_ready);

    dmarb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (found_idx),
        .wr_data (ram_wdata),
        .rd_addr (cursor_reg),
        .rd_data (ram_rbits)
    );
    assign ram_rdata = slot_entry_t'(ram_rbits);

    // First free slot at or after the cursor, else the first free slot overall
    always_comb begin
        free_vec = ~occ_reg;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            above_mask[i] = (SLOT_W'(i) >= cursor_reg);
        end
        pick_vec  = (|(free_vec & above_mask)) ? (free_vec & above_mask) : free_vec;
        first_vec = pick_vec & (~pick_vec + SLOT_COUNT'(1));
        found     = |free_vec;
        found_idx = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (first_vec[i]) begin
                found_idx = found_idx | SLOT_W'(i);
            end
        end
    end

    // Datapath terms shared by the operations
    always_comb begin
        cur_occ     = occ_reg[cursor_reg];
        cur_size    = PEND_W'(ram_rdata.size);
        pend_sum    = {1'b0, pending_reg} + (PEND_W + 1)'(in_reg.size);
        pass_sum    = {1'b0, pass_reg} + (PASS_W + 1)'(ram_rdata.size);
        pass_sat    = pass_sum[PASS_W] ? PASS_MAX : pass_sum[PASS_W-1:0];
        over_budget = pass_sat > PASS_W'(budget_reg);
        too_late    = in_reg.scanline > cutoff_reg;
        done_bytes  = (start_reg > pending_reg) ? (start_reg - pending_reg) : '0;
        cursor_inc  = (cursor_reg == SLOT_W'(SLOT_COUNT - 1)) ? '0
                                                              : cursor_reg + SLOT_W'(1);
        check_idx   = SLOT_W'(in_reg.slot_index);
    end

    // Execute one item: next state, memory write and result
    always_comb begin
        state_next   = state_reg;
        occ_next     = occ_reg;
        cursor_next  = cursor_reg;
        pending_next = pending_reg;
        start_next   = start_reg;
        peak_next    = peak_reg;
        pass_next    = pass_reg;
        res_next     = '0;
        has_result   = 1'b1;
        ram_we       = 1'b0;

        ram_wdata.src  = (in_reg.operation == OP_COPY) ? in_reg.src_addr : 32'd0;
        ram_wdata.dest = in_reg.dest_addr;
        ram_wdata.size = in_reg.size;
        ram_wdata.fill = (in_reg.operation == OP_FILL) ? in_reg.fill_value : 32'd0;
        if (in_reg.operation == OP_COPY) begin
            ram_wdata.kind = in_reg.wide_mode ? XK_COPY32 : XK_COPY16;
        end else begin
            ram_wdata.kind = in_reg.wide_mode ? XK_FILL32 : XK_FILL16;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (in_reg.operation) inside
                    OP_CLEAR: begin
                        occ_next             = '0;
                        cursor_next          = '0;
                        pending_next         = '0;
                        res_next.result_kind = RK_CLEARED;
                    end
                    OP_COPY, OP_FILL: begin
                        if (found) begin
                            ram_we                = commit;
                            occ_next[found_idx]   = (in_reg.size != 16'd0);
                            pending_next          = pend_sum[PEND_W] ? PEND_MAX
                                                                     : pend_sum[PEND_W-1:0];
                            res_next.result_kind  = RK_ACCEPTED;
                            res_next.slot         = 7'(found_idx);
                        end else begin
                            res_next.result_kind  = RK_REFUSED;
                        end
                    end
                    OP_BEGIN: begin
                        start_next             = pending_reg;
                        peak_next              = (pending_reg > peak_reg) ? pending_reg
                                                                          : peak_reg;
                        pass_next              = '0;
                        res_next.result_kind   = RK_STARTED;
                        res_next.bytes_pending = pending_reg;
                        res_next.peak_bytes    = peak_next;
                    end
                    OP_STEP: begin
                        if (!cur_occ) begin
                            // Nothing under the cursor: pass drained
                            res_next.result_kind = RK_ENDED;
                            res_next.end_reason  = ER_DRAINED;
                            res_next.bytes_done  = done_bytes;
                        end else begin
                            pass_next = pass_sat;
                            if (over_budget || too_late) begin
                                res_next.result_kind   = RK_ENDED;
                                res_next.end_reason    = over_budget ? ER_BUDGET : ER_CUTOFF;
                                res_next.bytes_done    = done_bytes;
                                res_next.bytes_pending = pending_reg;
                            end else begin
                                res_next.result_kind = RK_XFER;
                                res_next.xfer_kind   = ram_rdata.kind;
                                res_next.xfer_src    = ram_rdata.kind[0] ? 32'd0
                                                                         : ram_rdata.src;
                                res_next.xfer_dest   = ram_rdata.dest;
                                res_next.xfer_size   = ram_rdata.size;
                                res_next.xfer_value  = ram_rdata.kind[0] ? ram_rdata.fill
                                                                         : 32'd0;
                                occ_next[cursor_reg] = 1'b0;
                                pending_next         = (pending_reg > cur_size)
                                                       ? pending_reg - cur_size : '0;
                                cursor_next          = cursor_inc;
                            end
                        end
                    end
                    OP_SPACE: begin
                        res_next.result_kind = RK_SPACE;
                        if (in_reg.check_all) begin
                            res_next.space_free = ~(|occ_reg);
                        end else begin
                            res_next.space_free = (32'(in_reg.slot_index) < SLOT_COUNT)
                                                  && !occ_reg[check_idx];
                        end
                    end
                    default: begin
                        // Unknown operation: no result, no state change
                        has_result = 1'b0;
                    end
                endcase
                if (commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Result register handshake
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (commit && has_result) begin
            m_valid_next = 1'b1;
        end
    end

    // Control state and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            occ_reg     <= '0;
            cursor_reg  <= '0;
            pending_reg <= '0;
            start_reg   <= '0;
            peak_reg    <= '0;
            pass_reg    <= '0;
            budget_reg  <= BUDGET_RESET;
            cutoff_reg  <= CUTOFF_RESET;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (commit) begin
                occ_reg     <= occ_next;
                cursor_reg  <= cursor_next;
                pending_reg <= pending_next;
                start_reg   <= start_next;
                peak_reg    <= peak_next;
                pass_reg    <= pass_next;
            end
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_BUDGET: budget_reg <= cfg_wdata[BUDGET_W-1:0];
                    CFG_CUTOFF: cutoff_reg <= cfg_wdata[CUTOFF_W-1:0];
                    default:    budget_reg <= budget_reg;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            in_reg.operation  <= s_operation;
            in_reg.src_addr   <= s_src_addr;
            in_reg.dest_addr  <= s_dest_addr;
            in_reg.size       <= s_size;
            in_reg.wide_mode  <= s_wide_mode;
            in_reg.fill_value <= s_fill_value;
            in_reg.scanline   <= s_scanline;
            in_reg.slot_index <= s_slot_index;
            in_reg.check_all  <= s_check_all;
        end
        if (commit && has_result) begin
            res_reg <= res_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_result_kind   = res_reg.result_kind;
    assign m_slot          = res_reg.slot;
    assign m_xfer_kind     = res_reg.xfer_kind;
    assign m_xfer_src      = res_reg.xfer_src;
    assign m_xfer_dest     = res_reg.xfer_dest;
    assign m_xfer_size     = res_reg.xfer_size;
    assign m_xfer_value    = res_reg.xfer_value;
    assign m_end_reason    = res_reg.end_reason;
    assign m_bytes_done    = res_reg.bytes_done;
    assign m_bytes_pending = res_reg.bytes_pending;
    assign m_peak_bytes    = res_reg.peak_bytes;
    assign m_space_free    = res_reg.space_free;

    // A clear leaves every slot free
    a_clear_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && in_reg.operation == OP_CLEAR) |=> (occ_reg == '0))
        else $error("slots still occupied after clear");

    // A granted nonzero request occupies its slot
    a_grant_occupies: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && (in_reg.operation == OP_COPY || in_reg.operation == OP_FILL)
         && found && in_reg.size != 16'd0) |=> occ_reg[$past(found_idx)])
        else $error("granted slot not marked occupied");

    // An emitted transfer never has zero length
    a_xfer_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && res_reg.result_kind == RK_XFER) |-> (res_reg.xfer_size != 16'd0))
        else $error("transfer emitted from a free slot");

endmodule
